/* hw/rtl/led_matrix_text_scroller_macros.svh */
// Assertion macros shared by the scroller RTL.
// In synthesis builds the macros expand to nothing.
`ifndef LED_MATRIX_TEXT_SCROLLER_MACROS_SVH
`define LED_MATRIX_TEXT_SCROLLER_MACROS_SVH
`ifndef SYNTHESIS
// Checked property that is switched off while reset is high.
`define LMTS_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("led_matrix_text_scroller: check failed");
// Checked property that is also evaluated during reset.
`define LMTS_ASSERT_RESET(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("led_matrix_text_scroller: reset check failed");
`else
`define LMTS_ASSERT(label, clk, rst, prop)
`define LMTS_ASSERT_RESET(label, clk, prop)
`endif
`endif

/* hw/rtl/lmts_pkg.sv */
package lmts_pkg;

   // Frame and glyph geometry.
   localparam int GLYPH_COLS   = 6;
   localparam int FRAME_COLS   = 16;
   localparam int FRAME_ROWS   = 8;
   localparam int FONT_GLYPHS  = 8;
   localparam int START_OFFSET = 22;
   localparam int APPEND_BELOW = 15;
   localparam int OFFSET_W     = 5;
   localparam int GLYPH_ID_W   = 3;
   localparam int ROW_SEL_W    = 3;
   localparam int SHIFT_W      = GLYPH_COLS + START_OFFSET;

   localparam logic [7:0] CHAR_SPACE = 8'h20;

   // Glyph identifiers; blank is used for anything the font lacks.
   localparam logic [GLYPH_ID_W-1:0] GLYPH_BLANK = 3'd0;
   localparam logic [GLYPH_ID_W-1:0] GLYPH_H     = 3'd1;
   localparam logic [GLYPH_ID_W-1:0] GLYPH_E     = 3'd2;
   localparam logic [GLYPH_ID_W-1:0] GLYPH_L     = 3'd3;
   localparam logic [GLYPH_ID_W-1:0] GLYPH_O     = 3'd4;
   localparam logic [GLYPH_ID_W-1:0] GLYPH_W     = 3'd5;
   localparam logic [GLYPH_ID_W-1:0] GLYPH_R     = 3'd6;
   localparam logic [GLYPH_ID_W-1:0] GLYPH_D     = 3'd7;

   // Font rows, bit c is glyph column c.
   localparam logic [GLYPH_COLS-1:0] FONT_ROWS [FONT_GLYPHS][FRAME_ROWS] = '{
      '{6'h00, 6'h00, 6'h00, 6'h00, 6'h00, 6'h00, 6'h00, 6'h00},
      '{6'h00, 6'h33, 6'h33, 6'h3F, 6'h33, 6'h33, 6'h33, 6'h00},
      '{6'h00, 6'h3F, 6'h03, 6'h1F, 6'h03, 6'h03, 6'h3F, 6'h00},
      '{6'h00, 6'h03, 6'h03, 6'h03, 6'h03, 6'h03, 6'h3F, 6'h00},
      '{6'h00, 6'h1E, 6'h33, 6'h33, 6'h33, 6'h33, 6'h1E, 6'h00},
      '{6'h00, 6'h23, 6'h23, 6'h2B, 6'h3F, 6'h37, 6'h23, 6'h00},
      '{6'h00, 6'h1F, 6'h33, 6'h33, 6'h1F, 6'h33, 6'h33, 6'h00},
      '{6'h00, 6'h1F, 6'h33, 6'h33, 6'h33, 6'h33, 6'h1F, 6'h00}
   };

   typedef enum logic [1:0] {
      CMD_APPEND = 2'd0,
      CMD_START  = 2'd1,
      CMD_TICK   = 2'd2,
      CMD_CLEAR  = 2'd3
   } cmd_type;

   typedef struct packed {
      cmd_type    command;
      logic [7:0] char_code;
   } req_word_type;

   typedef struct packed {
      logic [FRAME_COLS-1:0] row0_bits;
      logic [FRAME_COLS-1:0] row1_bits;
      logic [FRAME_COLS-1:0] row2_bits;
      logic [FRAME_COLS-1:0] row3_bits;
      logic [FRAME_COLS-1:0] row4_bits;
      logic [FRAME_COLS-1:0] row5_bits;
      logic [FRAME_COLS-1:0] row6_bits;
      logic [FRAME_COLS-1:0] row7_bits;
      logic                  last_frame;
      logic                  glyph_error;
   } rsp_word_type;

   // One active glyph on the display.
   typedef struct packed {
      logic [GLYPH_ID_W-1:0] id;
      logic [OFFSET_W-1:0]   offset;
   } glyph_lane_type;

   typedef struct packed {
      logic [GLYPH_ID_W-1:0] id;
      logic                  unknown;
   } glyph_look_type;

   // Maps a character code to its glyph and flags characters the font lacks.
   function automatic glyph_look_type glyph_of(input logic [7:0] ch);
      glyph_look_type look;
      look.unknown = 1'b0;
      unique case (ch)
         "H": look.id = GLYPH_H;
         "E": look.id = GLYPH_E;
         "L": look.id = GLYPH_L;
         "O": look.id = GLYPH_O;
         "W": look.id = GLYPH_W;
         "R": look.id = GLYPH_R;
         "D": look.id = GLYPH_D;
         default: begin
            look.id      = GLYPH_BLANK;
            look.unknown = 1'b1;
         end
      endcase
      return look;
   endfunction

   function automatic logic [GLYPH_COLS-1:0] font_row(
      input logic [GLYPH_ID_W-1:0] id,
      input logic [ROW_SEL_W-1:0]  row
   );
      return FONT_ROWS[id][row];
   endfunction

endpackage

/* hw/rtl/lmts_ram.sv */
module lmts_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // One write port and one registered read port; a read of the address being
   // written returns the old contents.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* hw/rtl/lmts_render.sv */
module lmts_render import lmts_pkg::*; #(
   parameter int ACTIVE_GLYPHS = 4,
   localparam int CNT_W = $clog2(ACTIVE_GLYPHS + 1)
) (
   input  glyph_lane_type        lanes [ACTIVE_GLYPHS],
   input  logic [CNT_W-1:0]      lane_count,
   output logic [FRAME_COLS-1:0] frame_rows [FRAME_ROWS]
);

   // Places a glyph row so that glyph column c lands on frame column
   // c - GLYPH_COLS + offset; columns outside the frame fall away.
   function automatic logic [FRAME_COLS-1:0] place_row(
      input logic [GLYPH_COLS-1:0] bits,
      input logic [OFFSET_W-1:0]   offset
   );
      logic [SHIFT_W-1:0] wide;
      wide = SHIFT_W'(bits) << offset;
      return wide[GLYPH_COLS+FRAME_COLS-1:GLYPH_COLS];
   endfunction

   // Every occupied lane is drawn into every row and the lanes are ORed.
   always_comb begin
      for (int r = 0; r < FRAME_ROWS; r++) begin
         frame_rows[r] = '0;
         for (int k = 0; k < ACTIVE_GLYPHS; k++) begin
            if (CNT_W'(k) < lane_count) begin
               frame_rows[r] = frame_rows[r]
                  | place_row(font_row(lanes[k].id, ROW_SEL_W'(r)), lanes[k].offset);
            end
         end
      end
   end

endmodule

/* hw/rtl/led_matrix_text_scroller.sv */
// An accepted word is taken into the input register, and a frame tick leaves its
// frame in the result register. Throughput: one word per cycle while no frame
// waits on a stalled result; the whole update is one pass of logic between the
// input register and the result register, and the text buffer is read ahead.
// Reset clears the text, the glyph queue, the error flag and both valid bits;
// the text buffer itself is not cleared and needs no clearing pass.
`include "led_matrix_text_scroller_macros.svh"

module led_matrix_text_scroller import lmts_pkg::*; #(
   parameter int TEXT_MAX      = 32,
   parameter int ACTIVE_GLYPHS = 4
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  req_word_type req_word,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output rsp_word_type rsp_word
);

   localparam int LEN_W  = $clog2(TEXT_MAX + 1);
   localparam int ADDR_W = (TEXT_MAX > 1) ? $clog2(TEXT_MAX) : 1;
   localparam int CNT_W  = $clog2(ACTIVE_GLYPHS + 1);

   // Input and result registers.
   logic         in_valid_ff, in_valid_in;
   req_word_type in_word_ff, in_word_in;
   logic         rsp_valid_ff, rsp_valid_in;
   rsp_word_type rsp_word_ff, rsp_word_in;

   // Scroller state.
   logic [LEN_W-1:0]    text_length_ff, text_length_in;
   logic [LEN_W-1:0]    next_index_ff, next_index_in;
   logic [7:0]          first_char_ff, first_char_in;
   glyph_lane_type      lanes_ff [ACTIVE_GLYPHS];
   glyph_lane_type      lanes_in [ACTIVE_GLYPHS];
   logic [CNT_W-1:0]    queue_count_ff, queue_count_in;
   logic [OFFSET_W-1:0] newest_off_ff, newest_off_in;
   logic                error_flag_ff, error_flag_in;

   // Text buffer access and read-ahead bypass.
   logic              wr_en;
   logic [ADDR_W-1:0] wr_addr;
   logic [ADDR_W-1:0] rd_addr;
   logic [LEN_W-1:0]  rd_index;
   logic [7:0]        rd_data;
   logic              byp_valid_ff, byp_valid_in;
   logic [7:0]        byp_data_ff;
   logic [7:0]        next_char;

   // Handshake and tick datapath.
   logic                  produces, out_free, proc, accept;
   glyph_lane_type        lanes_dec   [ACTIVE_GLYPHS];
   glyph_lane_type        lanes_shift [ACTIVE_GLYPHS];
   glyph_lane_type        new_lane;
   logic                  drop;
   logic [CNT_W-1:0]      count_mid;
   logic [OFFSET_W-1:0]   newest_dec;
   logic                  advance, want_push, room;
   logic [LEN_W-1:0]      peek_index;
   glyph_look_type        look;
   logic [FRAME_COLS-1:0] frame_rows [FRAME_ROWS];

   // A word leaves the input register unless it is a frame that cannot be placed.
   assign produces  = in_valid_ff && (in_word_ff.command == CMD_TICK) && (queue_count_ff != '0);
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign proc      = in_valid_ff && (!produces || out_free);
   assign req_stall = in_valid_ff && !proc;
   assign accept    = req_valid && !req_stall;

   assign in_valid_in  = accept ? 1'b1 : (proc ? 1'b0 : in_valid_ff);
   assign in_word_in   = accept ? req_word : in_word_ff;
   assign rsp_valid_in = (proc && produces) ? 1'b1 : (out_free ? 1'b0 : rsp_valid_ff);

   // Frame drawn from the glyphs as they stand before this tick.
   lmts_render #(
      .ACTIVE_GLYPHS (ACTIVE_GLYPHS)
   ) u_render (
      .lanes      (lanes_ff),
      .lane_count (queue_count_ff),
      .frame_rows (frame_rows)
   );

   // The character after the current index is read ahead every cycle.
   assign rd_index     = (reset ? LEN_W'(0) : next_index_in) + LEN_W'(1);
   assign rd_addr      = rd_index[ADDR_W-1:0];
   assign wr_addr      = text_length_ff[ADDR_W-1:0];
   assign byp_valid_in = wr_en && (wr_addr == rd_addr);
   assign next_char    = byp_valid_ff ? byp_data_ff : rd_data;

   lmts_ram #(
      .WIDTH (8),
      .DEPTH (TEXT_MAX)
   ) u_text_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (in_word_ff.char_code),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Tick: move every glyph one column left and drop the front one once it
   // has left the frame.
   always_comb begin
      for (int k = 0; k < ACTIVE_GLYPHS; k++) begin
         lanes_dec[k]        = lanes_ff[k];
         lanes_dec[k].offset = lanes_ff[k].offset - OFFSET_W'(1);
      end
      drop = (lanes_ff[0].offset == '0);
      for (int k = 0; k < ACTIVE_GLYPHS - 1; k++) begin
         if (drop) begin
            lanes_shift[k] = lanes_dec[k + 1];
         end else begin
            lanes_shift[k] = lanes_dec[k];
         end
      end
      lanes_shift[ACTIVE_GLYPHS-1] = lanes_dec[ACTIVE_GLYPHS-1];
   end

   assign count_mid  = queue_count_ff - CNT_W'(drop);
   assign newest_dec = newest_off_ff - OFFSET_W'(1);
   assign peek_index = next_index_ff + LEN_W'(1);
   assign advance    = (count_mid != '0) && (newest_dec < OFFSET_W'(APPEND_BELOW))
                       && (next_index_ff < text_length_ff);
   assign want_push  = advance && (peek_index < text_length_ff) && (next_char != CHAR_SPACE);
   assign room       = count_mid < CNT_W'(ACTIVE_GLYPHS);
   assign look       = glyph_of((in_word_ff.command == CMD_START) ? first_char_ff : next_char);
   assign new_lane   = '{id: look.id, offset: OFFSET_W'(START_OFFSET)};

   // Next state and result for the word in the input register.
   always_comb begin
      text_length_in = text_length_ff;
      next_index_in  = next_index_ff;
      first_char_in  = first_char_ff;
      lanes_in       = lanes_ff;
      queue_count_in = queue_count_ff;
      newest_off_in  = newest_off_ff;
      error_flag_in  = error_flag_ff;
      wr_en          = 1'b0;
      if (proc) begin
         unique case (in_word_ff.command)
            CMD_APPEND: begin
               if (text_length_ff < LEN_W'(TEXT_MAX)) begin
                  wr_en          = 1'b1;
                  text_length_in = text_length_ff + LEN_W'(1);
                  if (text_length_ff == '0) begin
                     first_char_in = in_word_ff.char_code;
                  end
               end else begin
                  error_flag_in = 1'b1;
               end
            end
            CMD_START: begin
               next_index_in  = '0;
               queue_count_in = '0;
               if (text_length_ff == '0) begin
                  error_flag_in = 1'b1;
               end else begin
                  lanes_in[0]    = new_lane;
                  queue_count_in = CNT_W'(1);
                  newest_off_in  = OFFSET_W'(START_OFFSET);
                  if (look.unknown) begin
                     error_flag_in = 1'b1;
                  end
               end
            end
            CMD_TICK: begin
               if (queue_count_ff != '0) begin
                  lanes_in       = lanes_shift;
                  queue_count_in = count_mid;
                  newest_off_in  = newest_dec;
                  if (advance) begin
                     next_index_in = peek_index;
                  end
                  if (want_push) begin
                     if (look.unknown) begin
                        error_flag_in = 1'b1;
                     end
                     if (room) begin
                        for (int k = 0; k < ACTIVE_GLYPHS; k++) begin
                           if (CNT_W'(k) == count_mid) begin
                              lanes_in[k] = new_lane;
                           end
                        end
                        queue_count_in = count_mid + CNT_W'(1);
                        newest_off_in  = OFFSET_W'(START_OFFSET);
                     end else begin
                        error_flag_in = 1'b1;
                     end
                  end
               end
            end
            CMD_CLEAR: begin
               text_length_in = '0;
               next_index_in  = '0;
               queue_count_in = '0;
               error_flag_in  = 1'b0;
            end
            default: begin
               error_flag_in = error_flag_ff;
            end
         endcase
      end
   end

   // Result word for a frame tick.
   always_comb begin
      rsp_word_in.row0_bits   = frame_rows[0];
      rsp_word_in.row1_bits   = frame_rows[1];
      rsp_word_in.row2_bits   = frame_rows[2];
      rsp_word_in.row3_bits   = frame_rows[3];
      rsp_word_in.row4_bits   = frame_rows[4];
      rsp_word_in.row5_bits   = frame_rows[5];
      rsp_word_in.row6_bits   = frame_rows[6];
      rsp_word_in.row7_bits   = frame_rows[7];
      rsp_word_in.last_frame  = (queue_count_in == '0);
      rsp_word_in.glyph_error = error_flag_in;
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff    <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         text_length_ff <= '0;
         next_index_ff  <= '0;
         queue_count_ff <= '0;
         error_flag_ff  <= 1'b0;
         byp_valid_ff   <= 1'b0;
      end else begin
         in_valid_ff    <= in_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
         text_length_ff <= text_length_in;
         next_index_ff  <= next_index_in;
         queue_count_ff <= queue_count_in;
         error_flag_ff  <= error_flag_in;
         byp_valid_ff   <= byp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      in_word_ff    <= in_word_in;
      first_char_ff <= first_char_in;
      lanes_ff      <= lanes_in;
      newest_off_ff <= newest_off_in;
      byp_data_ff   <= in_word_ff.char_code;
      if (proc && produces) begin
         rsp_word_ff <= rsp_word_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

   // Checks on the scroller state.
   `LMTS_ASSERT(a_index_within_text, clock, reset, next_index_ff <= text_length_ff)
   `LMTS_ASSERT(a_queue_bounded, clock, reset, queue_count_ff <= CNT_W'(ACTIVE_GLYPHS))
   `LMTS_ASSERT(a_clear_empties, clock, reset,
      proc && (in_word_ff.command == CMD_CLEAR) |=> (queue_count_ff == '0) && !error_flag_ff)
   `LMTS_ASSERT(a_last_frame_flag, clock, reset,
      proc && produces && (queue_count_in == '0) |=> rsp_valid_ff && rsp_word_ff.last_frame)
   `LMTS_ASSERT_RESET(a_reset_idle, clock,
      reset |=> !rsp_valid_ff && !in_valid_ff && (queue_count_ff == '0))

endmodule

/* verif/led_matrix_text_scroller_tb.sv */
module led_matrix_text_scroller_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import lmts_pkg::*;

   localparam int TEXT_DEPTH    = 32;
   localparam int LANES         = 4;
   localparam int ENTRY_OFFSET  = 22;
   localparam int REFILL_BELOW  = 15;
   localparam int GLYPH_WIDTH   = 6;
   localparam int FRAME_WIDTH   = 16;
   localparam int WORDS_WANTED  = 1525;
   localparam int CALM_AFTER    = 1325;
   localparam int DUE_DEPTH     = 16;

   // Font pixels, bit c is glyph column c; row 0 is the top row.
   localparam logic [5:0] MARQUEE_FONT [8][8] = '{
      '{6'h00, 6'h00, 6'h00, 6'h00, 6'h00, 6'h00, 6'h00, 6'h00},
      '{6'h00, 6'h33, 6'h33, 6'h3F, 6'h33, 6'h33, 6'h33, 6'h00},
      '{6'h00, 6'h3F, 6'h03, 6'h1F, 6'h03, 6'h03, 6'h3F, 6'h00},
      '{6'h00, 6'h03, 6'h03, 6'h03, 6'h03, 6'h03, 6'h3F, 6'h00},
      '{6'h00, 6'h1E, 6'h33, 6'h33, 6'h33, 6'h33, 6'h1E, 6'h00},
      '{6'h00, 6'h23, 6'h23, 6'h2B, 6'h3F, 6'h37, 6'h23, 6'h00},
      '{6'h00, 6'h1F, 6'h33, 6'h33, 6'h1F, 6'h33, 6'h33, 6'h00},
      '{6'h00, 6'h1F, 6'h33, 6'h33, 6'h33, 6'h33, 6'h1F, 6'h00}
   };

   // Characters the random text is mostly built from.
   localparam logic [7:0] LETTERS [8] = '{"H", "E", "L", "O", "W", "R", "D", " "};

   localparam rsp_word_type FRAME_DARK         = '0;
   localparam rsp_word_type FRAME_DARK_FLAGGED = '{glyph_error: 1'b1, default: '0};

   typedef struct packed {
      cmd_type      command;
      logic [7:0]   char_code;
      logic         typed;
      rsp_word_type frame;
   } script_row_type;

   // Opening script. Typed frames are those of a glyph that has only just
   // entered beyond the right edge, so nothing is lit yet.
   localparam script_row_type SCRIPT [25] = '{
      '{CMD_TICK,   8'h00, 1'b0, FRAME_DARK},
      '{CMD_START,  8'h00, 1'b0, FRAME_DARK},
      '{CMD_TICK,   8'hFF, 1'b0, FRAME_DARK},
      '{CMD_CLEAR,  8'h00, 1'b0, FRAME_DARK},
      '{CMD_APPEND, "H",   1'b0, FRAME_DARK},
      '{CMD_START,  8'hFF, 1'b0, FRAME_DARK},
      '{CMD_TICK,   8'h00, 1'b1, FRAME_DARK},
      '{CMD_APPEND, " ",   1'b0, FRAME_DARK},
      '{CMD_APPEND, 8'h00, 1'b0, FRAME_DARK},
      '{CMD_APPEND, 8'hFF, 1'b0, FRAME_DARK},
      '{CMD_APPEND, "E",   1'b0, FRAME_DARK},
      '{CMD_APPEND, "L",   1'b0, FRAME_DARK},
      '{CMD_APPEND, "O",   1'b0, FRAME_DARK},
      '{CMD_APPEND, "W",   1'b0, FRAME_DARK},
      '{CMD_APPEND, "R",   1'b0, FRAME_DARK},
      '{CMD_APPEND, "D",   1'b0, FRAME_DARK},
      '{CMD_START,  8'h00, 1'b0, FRAME_DARK},
      '{CMD_TICK,   8'hFF, 1'b1, FRAME_DARK},
      '{CMD_TICK,   8'h00, 1'b0, FRAME_DARK},
      '{CMD_CLEAR,  8'hFF, 1'b0, FRAME_DARK},
      '{CMD_APPEND, " ",   1'b0, FRAME_DARK},
      '{CMD_APPEND, "O",   1'b0, FRAME_DARK},
      '{CMD_START,  8'h00, 1'b0, FRAME_DARK},
      '{CMD_TICK,   8'h00, 1'b1, FRAME_DARK_FLAGGED},
      '{CMD_TICK,   8'hFF, 1'b0, FRAME_DARK}
   };

   logic         clock     = 1'b0;
   logic         reset     = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_stall;
   req_word_type req_word  = '0;
   logic         rsp_valid;
   logic         rsp_stall = 1'b0;
   rsp_word_type rsp_word;

   // Predicted marquee state, as after reset.
   logic [7:0]        text_mem [TEXT_DEPTH];
   logic [5:0]        text_len   = '0;
   logic [5:0]        read_pos   = '0;
   logic [2:0]        lane_id  [LANES] = '{default: '0};
   logic signed [5:0] lane_off [LANES] = '{default: '0};
   logic [1:0]        front      = '0;
   logic [2:0]        lanes_used = '0;
   logic              sticky_err = 1'b0;

   // Predicted frames waiting to come out, oldest at the read count.
   rsp_word_type due_mem [DUE_DEPTH];
   int           due_wr = 0;
   int           due_rd = 0;
   rsp_word_type due_frame;
   int           mismatches = 0;
   int           words_sent = 0;
   int           stall_left = 0;
   bit           idling     = 1'b1;
   bit           made;
   int           text_n;
   int           ticks;

   led_matrix_text_scroller u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Looks up the glyph of a character; anything outside the font is blank
   // and raises the sticky error.
   function automatic logic [2:0] glyph_for_char(input logic [7:0] ch);
      case (ch)
         "H": return GLYPH_H;
         "E": return GLYPH_E;
         "L": return GLYPH_L;
         "O": return GLYPH_O;
         "W": return GLYPH_W;
         "R": return GLYPH_R;
         "D": return GLYPH_D;
         default: begin
            sticky_err = 1'b1;
            return GLYPH_BLANK;
         end
      endcase
   endfunction

   // Appends a glyph at the right-hand entry offset, unless every lane is busy.
   function automatic void queue_glyph(input logic [2:0] id);
      logic [1:0] slot;
      if (lanes_used >= LANES) begin
         sticky_err = 1'b1;
         return;
      end
      slot = front + lanes_used[1:0];
      lane_id[slot]  = id;
      lane_off[slot] = 6'(ENTRY_OFFSET);
      lanes_used++;
   endfunction

   // Applies one word to the predicted state; returns 1 with the frame that a
   // tick draws while text is on the display.
   function automatic bit advance_marquee(input req_word_type w, output rsp_word_type frame);
      logic [FRAME_WIDTH-1:0] rows [8];
      logic [1:0]             slot;
      int                     col;
      frame = '0;
      case (w.command)
         CMD_APPEND: begin
            if (text_len < TEXT_DEPTH) begin
               text_mem[text_len] = w.char_code;
               text_len++;
            end else begin
               sticky_err = 1'b1;
            end
            return 1'b0;
         end
         CMD_START: begin
            front      = '0;
            lanes_used = '0;
            read_pos   = '0;
            if (text_len == 0) sticky_err = 1'b1;
            else queue_glyph(glyph_for_char(text_mem[0]));
            return 1'b0;
         end
         CMD_CLEAR: begin
            text_len   = '0;
            read_pos   = '0;
            front      = '0;
            lanes_used = '0;
            sticky_err = 1'b0;
            return 1'b0;
         end
         default: ;
      endcase
      if (lanes_used == 0) return 1'b0;

      // Draw every active glyph, then move it one column to the left.
      for (int r = 0; r < 8; r++) rows[r] = '0;
      for (int k = 0; k < lanes_used; k++) begin
         slot = front + 2'(k);
         for (int r = 0; r < 8; r++) begin
            for (int c = 0; c < GLYPH_WIDTH; c++) begin
               col = c - GLYPH_WIDTH + int'(lane_off[slot]);
               if (MARQUEE_FONT[lane_id[slot]][r][c] && col >= 0 && col < FRAME_WIDTH)
                  rows[r][col] = 1'b1;
            end
         end
         lane_off[slot] = lane_off[slot] - 6'sd1;
      end

      // The front glyph leaves once it has passed the left edge.
      if (lane_off[front] < 0) begin
         front++;
         lanes_used--;
      end

      // Pull in the next character once the newest glyph is clear of the entry.
      if (lanes_used > 0) begin
         slot = front + lanes_used[1:0] - 2'd1;
         if (lane_off[slot] < REFILL_BELOW && read_pos < text_len) begin
            read_pos++;
            if (read_pos < text_len && text_mem[read_pos] != CHAR_SPACE)
               queue_glyph(glyph_for_char(text_mem[read_pos]));
         end
      end

      frame.row0_bits   = rows[0];
      frame.row1_bits   = rows[1];
      frame.row2_bits   = rows[2];
      frame.row3_bits   = rows[3];
      frame.row4_bits   = rows[4];
      frame.row5_bits   = rows[5];
      frame.row6_bits   = rows[6];
      frame.row7_bits   = rows[7];
      frame.last_frame  = (lanes_used == 0);
      frame.glyph_error = sticky_err;
      return 1'b1;
   endfunction

   function automatic logic [7:0] random_char();
      if ($urandom_range(0, 9) == 0) return 8'($urandom);
      return LETTERS[$urandom_range(0, 7)];
   endfunction

   // Offers one word, waits for it to be taken and records the frame it causes.
   task automatic put_word(input cmd_type cmd, input logic [7:0] ch, output bit produced);
      req_word_type w;
      rsp_word_type frame;
      w.command   = cmd;
      w.char_code = ch;
      if (idling && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_word  <= w;
      req_valid <= 1'b1;
      do @(posedge clock); while (req_stall !== 1'b0);
      produced = advance_marquee(w, frame);
      if (produced) begin
         due_mem[due_wr % DUE_DEPTH] = frame;
         due_wr++;
      end
      words_sent++;
   endtask

   task automatic check_field(input string name, input logic [15:0] want,
                              input logic [15:0] got);
      if (got !== want) begin
         $error("%s: expected %h, got %h", name, want, got);
         mismatches++;
      end
   endtask

   // Result side stalls in random bursts.
   always @(posedge clock) begin
      if (reset || !idling) begin
         rsp_stall  <= 1'b0;
         stall_left <= 0;
      end else if (stall_left != 0) begin
         stall_left <= stall_left - 1;
      end else if ($urandom_range(0, 5) == 0) begin
         rsp_stall  <= 1'b1;
         stall_left <= $urandom_range(0, 3);
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // Every frame taken is compared with the oldest one predicted.
   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && rsp_stall == 1'b0) begin
         if (due_rd == due_wr) begin
            $error("frame word arrived with none expected");
            mismatches++;
         end else begin
            due_frame = due_mem[due_rd % DUE_DEPTH];
            due_rd++;
            check_field("row0_bits", due_frame.row0_bits, rsp_word.row0_bits);
            check_field("row1_bits", due_frame.row1_bits, rsp_word.row1_bits);
            check_field("row2_bits", due_frame.row2_bits, rsp_word.row2_bits);
            check_field("row3_bits", due_frame.row3_bits, rsp_word.row3_bits);
            check_field("row4_bits", due_frame.row4_bits, rsp_word.row4_bits);
            check_field("row5_bits", due_frame.row5_bits, rsp_word.row5_bits);
            check_field("row6_bits", due_frame.row6_bits, rsp_word.row6_bits);
            check_field("row7_bits", due_frame.row7_bits, rsp_word.row7_bits);
            check_field("last_frame", 16'(due_frame.last_frame), 16'(rsp_word.last_frame));
            check_field("glyph_error", 16'(due_frame.glyph_error),
                        16'(rsp_word.glyph_error));
         end
      end
   end

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Opening script; typed frames replace the predicted ones.
      foreach (SCRIPT[i]) begin
         put_word(SCRIPT[i].command, SCRIPT[i].char_code, made);
         if (SCRIPT[i].typed && made) begin
            due_mem[(due_wr - 1) % DUE_DEPTH] = SCRIPT[i].frame;
         end
      end

      // Random part: mostly whole scrolls of random text, with stray words
      // dropped in before and during them.
      while (words_sent < WORDS_WANTED) begin
         if (words_sent > CALM_AFTER) idling = 1'b0;
         if ($urandom_range(0, 9) == 0) begin
            put_word(cmd_type'($urandom_range(0, 3)), 8'($urandom), made);
         end else begin
            if ($urandom_range(0, 3) != 0) put_word(CMD_CLEAR, 8'($urandom), made);
            text_n = ($urandom_range(0, 9) == 0) ? $urandom_range(28, 36)
                                                 : $urandom_range(1, 8);
            repeat (text_n) put_word(CMD_APPEND, random_char(), made);
            put_word(CMD_START, 8'($urandom), made);
            ticks = 0;
            while (lanes_used != 0 && ticks < 600) begin
               if ($urandom_range(0, 59) == 0)
                  put_word(cmd_type'($urandom_range(0, 3)), random_char(), made);
               else
                  put_word(CMD_TICK, 8'($urandom), made);
               ticks++;
            end
            repeat ($urandom_range(0, 2)) put_word(CMD_TICK, 8'($urandom), made);
         end
      end
      req_valid <= 1'b0;

      while (due_rd != due_wr) @(posedge clock);
      repeat (4) @(posedge clock);
      if (mismatches == 0) $display("ALL CHECKS PASSED");
      else $display("CHECKS FAILED");
      $finish;
   end

   initial begin
      #400_000;
      $display("CHECKS FAILED");
      $finish;
   end

endmodule
